// ===== rtl/core/css_name_scanner_unit_defines.svh =====
// Assertion macros used by the scanner RTL.
// Each expects clk and rst_n in scope.
`ifndef CSS_NAME_SCANNER_UNIT_DEFINES_SVH
`define CSS_NAME_SCANNER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CSSNS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSSNS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cssns_pkg.sv =====
`default_nettype none

package cssns_pkg;

    typedef enum logic [1:0] {
        PH_NAME   = 2'd0,
        PH_BSLASH = 2'd1,
        PH_HEX    = 2'd2,
        PH_CR     = 2'd3
    } phase_t;

    localparam logic [15:0] CH_LF     = 16'd10;
    localparam logic [15:0] CH_FF     = 16'd12;
    localparam logic [15:0] CH_CR     = 16'd13;
    localparam logic [15:0] CH_TAB    = 16'd9;
    localparam logic [15:0] CH_SPACE  = 16'd32;
    localparam logic [15:0] CH_BSLASH = 16'd92;
    localparam logic [15:0] CH_NUL    = 16'd0;
    localparam logic [2:0]  MAX_HEX_DIGITS = 3'd6;

    typedef struct packed {
        logic        length_saturated;
        logic        ended_by_source_end;
        logic [1:0]  reconsume_count;
        logic [15:0] name_length;
    } result_t;

    typedef struct packed {
        logic    emit;
        result_t res;
    } step_out_t;

    function automatic logic is_hex(input logic [15:0] c);
        return (c inside {[16'd48:16'd57], [16'd65:16'd70], [16'd97:16'd102]});
    endfunction

    function automatic logic is_newline(input logic [15:0] c);
        return (c == CH_LF) || (c == CH_CR) || (c == CH_FF);
    endfunction

    function automatic logic is_space(input logic [15:0] c);
        return is_newline(c) || (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_name_unit(input logic [15:0] c);
        return (c inside {[16'd65:16'd90], [16'd97:16'd122], [16'd48:16'd57],
                          16'd45, 16'd95, [16'h0080:16'hFFFF]});
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cssns_step.sv =====
`default_nettype none

// One scan step: next state and optional result from current state and one unit.
module cssns_step #(
    parameter int LENGTH_WIDTH = 16
) (
    input  var cssns_pkg::phase_t    phase,
    input  wire [2:0]                hex_cnt,
    input  wire [LENGTH_WIDTH-1:0]   count,
    input  wire                      ovf,
    input  wire [15:0]               code_unit,
    input  wire                      source_end,
    output cssns_pkg::phase_t        phase_next,
    output logic [2:0]               hex_cnt_next,
    output logic [LENGTH_WIDTH-1:0]  count_next,
    output logic                     ovf_next,
    output cssns_pkg::step_out_t     step_out
);
    import cssns_pkg::*;

    localparam logic [LENGTH_WIDTH-1:0] CountMax = '1;

    logic [1:0]              add;
    logic [LENGTH_WIDTH:0]   sum;
    logic [LENGTH_WIDTH+15:0] count_ext;
    logic                    hi_nz;
    phase_t                  ph;
    logic [2:0]              hc;

    always_comb
    begin
        ph                    = phase;
        hc                    = hex_cnt;
        add                   = 2'd0;
        step_out.emit         = 1'b0;
        // length clamp to 16 bits for wide counters
        step_out.res.name_length         = hi_nz ? 16'hFFFF : count_ext[15:0];
        step_out.res.length_saturated    = ovf | hi_nz;
        step_out.res.reconsume_count     = 2'd0;
        step_out.res.ended_by_source_end = 1'b0;

        case (phase)
            PH_BSLASH:
            begin
                if (source_end)
                begin
                    step_out.emit = 1'b1;
                    step_out.res.reconsume_count = 2'd1;
                    step_out.res.ended_by_source_end = 1'b1;
                end
                else if (is_newline(code_unit) || code_unit == CH_NUL)
                begin
                    step_out.emit = 1'b1;
                    step_out.res.reconsume_count = 2'd2;
                end
                else
                begin
                    add = 2'd2;
                    ph  = is_hex(code_unit) ? PH_HEX : PH_NAME;
                    hc  = is_hex(code_unit) ? 3'd1 : 3'd0;
                end
            end
            default:
            begin
                if (source_end)
                begin
                    step_out.emit = 1'b1;
                    step_out.res.ended_by_source_end = 1'b1;
                end
                else if (phase == PH_HEX && is_hex(code_unit) && hex_cnt < MAX_HEX_DIGITS)
                begin
                    add = 2'd1;
                    hc  = hex_cnt + 3'd1;
                end
                else if (phase == PH_HEX && is_space(code_unit))
                begin
                    add = 2'd1;
                    hc  = 3'd0;
                    ph  = (code_unit == CH_CR) ? PH_CR : PH_NAME;
                end
                else if (phase == PH_CR && code_unit == CH_LF)
                begin
                    add = 2'd1;
                    ph  = PH_NAME;
                end
                else
                begin
                    // name unit, backslash or name end
                    ph = PH_NAME;
                    hc = 3'd0;
                    if (is_name_unit(code_unit))
                    begin
                        add = 2'd1;
                    end
                    else if (code_unit == CH_BSLASH)
                    begin
                        ph = PH_BSLASH;
                    end
                    else
                    begin
                        step_out.emit = 1'b1;
                        step_out.res.reconsume_count = 2'd1;
                    end
                end
            end
        endcase
    end

    // saturating counter; reaching the maximum also sets the flag
    assign sum = {1'b0, count} + {{(LENGTH_WIDTH-1){1'b0}}, add};

    assign count_ext = {{16{1'b0}}, count};
    assign hi_nz     = |count_ext[LENGTH_WIDTH+15:16];

    always_comb
    begin
        if (step_out.emit)
        begin
            phase_next   = PH_NAME;
            hex_cnt_next = 3'd0;
            count_next   = '0;
            ovf_next     = 1'b0;
        end
        else
        begin
            phase_next   = ph;
            hex_cnt_next = hc;
            if (add != 2'd0 && sum >= {1'b0, CountMax})
            begin
                count_next = CountMax;
                ovf_next   = 1'b1;
            end
            else
            begin
                count_next = sum[LENGTH_WIDTH-1:0];
                ovf_next   = ovf;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/css_name_scanner_unit.sv =====
// An input beat passes through the input register, then the scanner step and the result register.
// Throughput: one code unit per cycle while m_tready is high; a waiting result holds the
// step, so only the input register can still fill until the result drains.
// The rate is set by the combinational scanner step between the two registers.
// A result is produced only for the unit that ends the name (0 or 1 result per beat).
// Reset (rst_n low, asynchronous) empties both registers and returns the scanner to
// the start of a name with a zero length count.
`default_nettype none

`include "css_name_scanner_unit_defines.svh"

module css_name_scanner_unit #(
    parameter int LENGTH_WIDTH = 16   // internal length counter width, 4..32
) (
    input  wire         clk,
    input  wire         rst_n,

    // input stream: one UTF-16 code unit per beat
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [15:0]  s_tdata,   // [15:0] code_unit
    input  wire         s_tuser,   // [0] source_end (code_unit ignored when set)

    // result stream: one beat per scanned name
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata    // [15:0] name_length, [17:16] reconsume_count,
                                   // [18] ended_by_source_end, [19] length_saturated,
                                   // [23:20] zero
);
    import cssns_pkg::*;

    localparam logic [LENGTH_WIDTH-1:0] CountMax = '1;

    // input register
    logic        in_valid_reg;
    logic [15:0] in_code_reg;
    logic        in_end_reg;

    // scanner state
    phase_t                  phase_reg, phase_next;
    logic [2:0]              hex_cnt_reg, hex_cnt_next;
    logic [LENGTH_WIDTH-1:0] count_reg, count_next;
    logic                    ovf_reg, ovf_next;

    // result register
    logic    out_valid_reg;
    result_t out_res_reg;

    step_out_t step_out;
    logic      advance;

    // The step retires when the result register is free or draining this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    cssns_step #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_step (
        .phase        (phase_reg),
        .hex_cnt      (hex_cnt_reg),
        .count        (count_reg),
        .ovf          (ovf_reg),
        .code_unit    (in_code_reg),
        .source_end   (in_end_reg),
        .phase_next   (phase_next),
        .hex_cnt_next (hex_cnt_next),
        .count_next   (count_next),
        .ovf_next     (ovf_next),
        .step_out     (step_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_code_reg <= s_tdata;
            in_end_reg  <= s_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_NAME;
            hex_cnt_reg <= 3'd0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            hex_cnt_reg <= hex_cnt_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step_out.emit;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_out.emit)
        begin
            out_res_reg <= step_out.res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_res_reg};

    // a name end always restarts the scanner from a clean state
    `CSSNS_ASSERT_NEXT(a_restart, advance && step_out.emit,
        phase_reg == PH_NAME && count_reg == '0 && !ovf_reg, "scanner not cleared after result")
    // overflow flag only with a saturated counter
    `CSSNS_ASSERT_NOW(a_ovf_sat, ovf_reg, count_reg == CountMax, "overflow without saturation")
    // hex digit count tracks the escape phase
    `CSSNS_ASSERT_NOW(a_hex_cnt, phase_reg == PH_HEX,
        hex_cnt_reg != 3'd0 && hex_cnt_reg <= MAX_HEX_DIGITS, "bad hex digit count")
    `CSSNS_ASSERT_NOW(a_hex_idle, phase_reg != PH_HEX, hex_cnt_reg == 3'd0,
        "hex digit count outside escape")
    // reconsume count never exceeds two
    `CSSNS_ASSERT_NOW(a_reconsume, m_tvalid, m_tdata[17:16] != 2'd3, "reconsume count out of range")

endmodule

`default_nettype wire
